// ===== rtl/apdc_pkg.sv =====
package apdc_pkg;

    localparam int CORES   = 4;
    localparam int ENTRIES = 64;
    localparam int PC_BITS = 32;

    localparam int CORE_W  = $clog2(CORES);
    localparam int ENTRY_W = $clog2(ENTRIES);
    localparam int FILL_W  = $clog2(ENTRIES + 1);
    localparam int ADDR_W  = CORE_W + ENTRY_W;
    localparam int DEPTH   = CORES * ENTRIES;
    localparam int CNT_W   = 32;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(ENTRIES);
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

    typedef struct packed {
        logic [1:0]  core;
        logic [3:0]  first_type;
        logic [7:0]  first_size;
        logic [31:0] first_pc;
        logic [3:0]  second_type;
        logic [7:0]  second_size;
        logic [31:0] second_pc;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  slot;
        logic        is_new;
        logic [31:0] occurrences;
        logic        overflow;
        logic [31:0] total_events;
    } out_item_t;

    typedef struct packed {
        logic [3:0]         acc_type;
        logic [7:0]         acc_size;
        logic [PC_BITS-1:0] pc;
    } acc_key_t;

    typedef struct packed {
        acc_key_t first;
        acc_key_t second;
    } key_pair_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic issue;
        logic finish_hit;
        logic finish_miss;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic exhausted;
    } dp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== rtl/apdc_ctrl.sv =====
module apdc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  apdc_pkg::dp_status_t status,
    output apdc_pkg::dp_cmd_t    cmd,
    output logic                busy
);
    import apdc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.issue       = 1'b1;
                cmd.finish_hit  = status.hit;
                cmd.finish_miss = status.exhausted;
                if (status.hit || status.exhausted)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/apdc_dp.sv =====
module apdc_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  apdc_pkg::in_item_t   item,
    input  apdc_pkg::dp_cmd_t    cmd,
    output apdc_pkg::dp_status_t status,
    output logic                 done,
    output apdc_pkg::out_item_t  result
);
    import apdc_pkg::*;

    // Key pairs and counts of all cores, one row per (core, slot).
    key_pair_t        key_mem [DEPTH];
    logic [CNT_W-1:0] occ_mem [DEPTH];

    key_pair_t           rd_key_reg;
    logic [CNT_W-1:0]    rd_occ_reg;

    key_pair_t           key_reg;
    logic [CORE_W-1:0]   core_reg;
    logic [FILL_W-1:0]   n_reg;
    logic [FILL_W-1:0]   scan_idx_reg;
    logic [FILL_W-1:0]   scan_idx_next;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    logic [ENTRY_W-1:0]  pend_idx_reg;
    logic [FILL_W-1:0]   fill_reg [CORES];
    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    total_next;
    logic                done_reg;
    out_item_t           result_reg;
    out_item_t           result_next;

    key_pair_t           in_key;
    logic [CORE_W-1:0]   in_core;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                table_full;
    logic                key_we;
    logic                occ_we;
    logic [ENTRY_W-1:0]  wr_idx;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CNT_W-1:0]    wr_occ;
    logic                finish;

    assign in_core                = item.core[CORE_W-1:0];
    assign in_key.first.acc_type  = item.first_type;
    assign in_key.first.acc_size  = item.first_size;
    assign in_key.first.pc        = item.first_pc[PC_BITS-1:0];
    assign in_key.second.acc_type = item.second_type;
    assign in_key.second.acc_size = item.second_size;
    assign in_key.second.pc       = item.second_pc[PC_BITS-1:0];

    assign rd_en   = cmd.issue && (scan_idx_reg != n_reg);
    assign rd_addr = {core_reg, scan_idx_reg[ENTRY_W-1:0]};

    assign status.hit       = pend_valid_reg && (rd_key_reg == key_reg);
    assign status.exhausted = !pend_valid_reg && (scan_idx_reg == n_reg);

    assign table_full = (n_reg == FILL_FULL);
    assign finish     = cmd.finish_hit || cmd.finish_miss;
    assign wr_idx     = cmd.finish_hit ? pend_idx_reg : n_reg[ENTRY_W-1:0];
    assign wr_addr    = {core_reg, wr_idx};
    assign wr_occ     = cmd.finish_hit ? sat_inc(rd_occ_reg) : CNT_W'(1);
    assign key_we     = cmd.finish_miss && !table_full;
    assign occ_we     = cmd.finish_hit || key_we;
    assign total_next = sat_inc(total_reg);

    always_comb
    begin
        scan_idx_next   = scan_idx_reg;
        pend_valid_next = 1'b0;
        if (cmd.load)
        begin
            scan_idx_next = '0;
        end
        else if (rd_en)
        begin
            scan_idx_next   = scan_idx_reg + FILL_W'(1);
            pend_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        result_next              = '0;
        result_next.total_events = total_next;
        if (cmd.finish_hit || key_we)
        begin
            result_next.slot        = 6'(wr_idx);
            result_next.is_new      = key_we;
            result_next.occurrences = wr_occ;
        end
        else
        begin
            result_next.overflow = 1'b1;
        end
    end

    // Table memories: one read and one write port, read data registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_occ_reg <= occ_mem[rd_addr];
        end
        if (key_we)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        if (occ_we)
        begin
            occ_mem[wr_addr] <= wr_occ;
        end
    end

    // Item payload and search bookkeeping.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= in_key;
            core_reg <= in_core;
            n_reg    <= fill_reg[in_core];
        end
        if (rd_en)
        begin
            pend_idx_reg <= scan_idx_reg[ENTRY_W-1:0];
        end
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            total_reg      <= '0;
            done_reg       <= 1'b0;
            for (int c = 0; c < CORES; c++)
            begin
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            scan_idx_reg   <= scan_idx_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= finish;
            if (finish)
            begin
                total_reg <= total_next;
            end
            if (key_we)
            begin
                fill_reg[core_reg] <= n_reg + FILL_W'(1);
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/access_pair_dedup_counter.sv =====
// Channel  | Handshake            | Payload            | Direction
// ---------+----------------------+--------------------+----------
// input    | start, busy          | item   (in_item_t) | in
// result   | done (1-cycle pulse) | result (out_item_t)| out
//
// An item is taken at a clock edge where start is high and busy is low.
// The item is loaded into the datapath registers, then the search scans the selected core's table
// one entry per cycle through the registered read port of the table memory:
// a hit finishes the search at the matching slot and a miss once all n filled
// entries have been read (at once when the table is empty), where n is that core's
// fill level (at most 64). The result pulse follows in the next cycle.
// Reset clears the fill levels, the event total and the control state; the
// table memories are not cleared. The receiver cannot stall the result.
module access_pair_dedup_counter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  apdc_pkg::in_item_t  item,
    output logic                done,
    output apdc_pkg::out_item_t result
);
    import apdc_pkg::*;

    // Command and status buses between the controller and the datapath.
    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences load, search and finish for each item.
    apdc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // The datapath holds the tables, the fill levels, the event total and
    // the result register.
    apdc_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .done   (done),
        .result (result)
    );

`ifndef SYNTHESIS
    // A result only follows a cycle in which an item was in progress.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an item in progress");

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start a search");

    // A dropped pair reports no slot, no new entry and no count.
    a_overflow_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |->
            (!result.is_new && result.occurrences == '0 && result.slot == '0))
        else $error("overflow result carries entry data");

    // A newly appended entry always starts with a count of one.
    a_new_count_one: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_new) |-> (result.occurrences == 32'd1 && !result.overflow))
        else $error("new entry with wrong count");
`endif

endmodule
